[rtl/core/tsma_pkg.sv]
// Package for the thermistor temperature block: sizes, constants, register
// indexes and the configuration struct. No dependencies.
package tsma_pkg;

  localparam int WINDOW_LEN = 12;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W = $clog2(WINDOW_LEN * 4095 + 1);
  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int MEAN_S = 24;
  localparam int MEAN_K_W = MEAN_S;
  localparam logic [MEAN_K_W-1:0] MEAN_K =
    MEAN_K_W'(((64'd1 << MEAN_S) + WINDOW_LEN - 1) / WINDOW_LEN);

  localparam logic [11:0] FULL_SCALE = 12'd4095;
  localparam logic [15:0] R_MAX = 16'hFFFF;
  localparam logic [39:0] LN2_Q32 = 40'd2977044472;
  localparam logic signed [17:0] T_LOW = -18'sd27315;
  localparam logic signed [17:0] T_HIGH = 18'sd100000;
  localparam logic [16:0] KELVIN_CENTI = 17'd27315;
  localparam logic [16:0] Q_LIMIT = 17'd127315;
  localparam logic [4:0] LN_STEPS = 5'd27;

  localparam logic [15:0] SERIES_RESET = 16'd10000;
  localparam logic [39:0] COEF_A_RESET = 40'd312718699126;
  localparam logic [39:0] COEF_B_RESET = 40'd66987385000;
  localparam logic [39:0] COEF_C_RESET = 40'd18295874;

  localparam int PADDR_W = 5;
  localparam logic [1:0] REG_SERIES = 2'd0;
  localparam logic [1:0] REG_COEF_A = 2'd1;
  localparam logic [1:0] REG_COEF_B = 2'd2;
  localparam logic [1:0] REG_COEF_C = 2'd3;

  typedef struct packed {
    logic [15:0] series_resistance;
    logic [39:0] coef_a;
    logic [39:0] coef_b;
    logic [39:0] coef_c;
  } tsma_cfg_t;

endpackage

[rtl/core/tsma_if.sv]
// Valid/ready channel interfaces for converter samples and results.
// Depends on nothing.
interface tsma_in_if;
  logic valid;
  logic ready;
  logic [11:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface tsma_out_if;
  logic valid;
  logic ready;
  logic [11:0] filtered_level;
  logic [15:0] resistance_ohms;
  logic signed [17:0] temperature_centi_c;
  logic range_fault;
  modport source (output valid, output filtered_level, output resistance_ohms,
                  output temperature_centi_c, output range_fault, input ready);
  modport sink (input valid, input filtered_level, input resistance_ohms,
                input temperature_centi_c, input range_fault, output ready);
endinterface

[rtl/core/thermistor_temperature_sma_top.sv]
// Top level: configuration registers, front end, mean queue and back end.
// Depends on tsma_pkg, tsma_if, tsma_front, tsma_fifo and tsma_back.
// Each sample takes a resistance division (skipped at full scale), 27 squarings on
// the shared multiplier and a reciprocal division, both bit-serial; a zero mean or
// zero resistance ends early. The back end pops a new mean only when idle.
// Reset (synchronous) clears the window, sum and queue and loads the default registers.
module thermistor_temperature_sma_top (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [tsma_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready,
  tsma_in_if.sink adc_in,
  tsma_out_if.source result_out
);
  import tsma_pkg::*;

  tsma_cfg_t cfg;
  logic q_full;
  logic q_push;
  logic [11:0] q_push_mean;
  logic q_pop;
  logic q_valid;
  logic [11:0] q_mean;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.series_resistance <= SERIES_RESET;
      cfg.coef_a <= COEF_A_RESET;
      cfg.coef_b <= COEF_B_RESET;
      cfg.coef_c <= COEF_C_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        REG_SERIES: cfg.series_resistance <= pwdata[15:0];
        REG_COEF_A: cfg.coef_a <= pwdata[39:0];
        REG_COEF_B: cfg.coef_b <= pwdata[39:0];
        REG_COEF_C: cfg.coef_c <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_SERIES: prdata = {48'b0, cfg.series_resistance};
      REG_COEF_A: prdata = {24'b0, cfg.coef_a};
      REG_COEF_B: prdata = {24'b0, cfg.coef_b};
      REG_COEF_C: prdata = {24'b0, cfg.coef_c};
      default: prdata = '0;
    endcase
  end

  tsma_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adc_in (adc_in),
    .q_full (q_full),
    .q_push (q_push),
    .q_mean (q_push_mean)
  );

  tsma_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_mean),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_mean)
  );

  tsma_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_mean  (q_mean),
    .q_pop   (q_pop),
    .res_out (result_out)
  );
endmodule

[rtl/core/tsma_front.sv]
// Front end: sample window, running sum and window mean.
// Depends on tsma_pkg and tsma_in_if.
module tsma_front (
  input  logic clk,
  input  logic rst,
  tsma_in_if.sink adc_in,
  input  logic q_full,
  output logic q_push,
  output logic [11:0] q_mean
);
  import tsma_pkg::*;

  logic [SAMPLE_W-1:0] window [WINDOW_LEN];
  logic [SUM_W-1:0] running_sum;
  logic [SLOT_W-1:0] oldest_slot;
  logic pend;
  logic accept;
  logic [SUM_W+MEAN_K_W-1:0] prod;
  logic [SUM_W+MEAN_K_W-MEAN_S-1:0] mean_wide;

  assign adc_in.ready = !pend || !q_full;
  assign accept = adc_in.valid && adc_in.ready;
  assign q_push = pend && !q_full;

  assign prod = (SUM_W+MEAN_K_W)'(running_sum) * (SUM_W+MEAN_K_W)'(MEAN_K);
  assign mean_wide = prod[SUM_W+MEAN_K_W-1:MEAN_S];
  assign q_mean = (mean_wide > (SUM_W+MEAN_K_W-MEAN_S)'(FULL_SCALE)) ? FULL_SCALE
                                                                    : mean_wide[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
      running_sum <= '0;
      oldest_slot <= '0;
      pend <= 1'b0;
    end else begin
      if (accept) begin
        window[oldest_slot] <= adc_in.adc_sample;
        running_sum <= running_sum - SUM_W'(window[oldest_slot])
                       + SUM_W'(adc_in.adc_sample);
        oldest_slot <= (oldest_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0
                                                                 : oldest_slot + SLOT_W'(1);
        pend <= 1'b1;
      end else if (q_push) begin
        pend <= 1'b0;
      end
    end
  end
endmodule

[rtl/core/tsma_fifo.sv]
// Two-entry queue of window means between the front and back ends.
// Depends on nothing.
module tsma_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [11:0] push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output logic [11:0] data
);
  logic [11:0] mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

[rtl/core/tsma_back.sv]
// Back end: resistance division, fixed-point logarithm, Steinhart-Hart
// polynomial and reciprocal on a shared multiplier and divider.
// Depends on tsma_pkg and tsma_out_if.
module tsma_back (
  input  logic clk,
  input  logic rst,
  input  tsma_pkg::tsma_cfg_t cfg,
  input  logic q_valid,
  input  logic [11:0] q_mean,
  output logic q_pop,
  tsma_out_if.source res_out
);
  import tsma_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DCHK = 13'b0000000000010,
    S_DRUN = 13'b0000000000100,
    S_DFIN = 13'b0000000001000,
    S_LOG  = 13'b0000000010000,
    S_MUL1 = 13'b0000000100000,
    S_MUL2 = 13'b0000001000000,
    S_SQ   = 13'b0000010000000,
    S_L    = 13'b0000100000000,
    S_L2   = 13'b0001000000000,
    S_L3   = 13'b0010000000000,
    S_CL3  = 13'b0100000000000,
    S_BL   = 13'b1000000000000
  } state_t;

  state_t state;
  state_t ret;
  logic done;
  logic [11:0] mean_q;
  logic [15:0] r_q;
  logic fault_q;
  logic signed [17:0] t_q;
  logic [39:0] mul_a;
  logic [39:0] mul_b;
  logic [79:0] acc;
  logic [26:0] frac;
  logic [3:0] k;
  logic [4:0] cnt;
  logic [30:0] l_q;
  logic [51:0] d_q;
  logic [55:0] num;
  logic [51:0] den;
  logic [67:0] dsh;
  logic [16:0] quo;
  logic div_temp;

  logic [3:0] k_c;
  logic [30:0] m_init;
  logic [31:0] m2;
  logic [30:0] m_n;
  logic [26:0] frac_n;
  logic [51:0] d_n;
  logic [68:0] lim;
  logic ge;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (r_q[i]) begin
        k_c = 4'(i);
      end
    end
  end

  assign m_init = 31'({15'b0, r_q} << (5'd30 - {1'b0, k_c}));
  assign m2 = acc[61:30];
  assign m_n = m2[31] ? m2[31:1] : m2[30:0];
  assign frac_n = {frac[25:0], m2[31]};
  assign d_n = d_q + 52'(acc[70:27]);
  assign lim = div_temp ? {den, 17'b0} : {1'b0, den, 16'b0};
  assign ge = ({12'b0, num} >= dsh);

  assign q_pop = (state == S_IDLE) && q_valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      done <= 1'b0;
      res_out.valid <= 1'b0;
    end else begin
      if (done && (!res_out.valid || res_out.ready)) begin
        res_out.valid <= 1'b1;
        res_out.filtered_level <= mean_q;
        res_out.resistance_ohms <= r_q;
        res_out.temperature_centi_c <= t_q;
        res_out.range_fault <= fault_q;
        done <= 1'b0;
      end else if (res_out.valid && res_out.ready) begin
        res_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            mean_q <= q_mean;
            if (q_mean == 12'd0) begin
              r_q <= '0;
              fault_q <= 1'b1;
              t_q <= T_LOW;
              done <= 1'b1;
            end else if (q_mean == FULL_SCALE) begin
              r_q <= R_MAX;
              fault_q <= 1'b1;
              state <= S_LOG;
            end else begin
              fault_q <= 1'b0;
              num <= 56'(28'(cfg.series_resistance) * 28'(q_mean));
              den <= 52'(FULL_SCALE - q_mean);
              div_temp <= 1'b0;
              state <= S_DCHK;
            end
          end
        end
        S_DCHK: begin
          if ({13'b0, num} >= lim) begin
            if (div_temp) begin
              t_q <= T_HIGH;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              r_q <= R_MAX;
              fault_q <= 1'b1;
              state <= S_LOG;
            end
          end else begin
            dsh <= div_temp ? {den, 16'b0} : {1'b0, den, 15'b0};
            cnt <= div_temp ? 5'd17 : 5'd16;
            quo <= '0;
            state <= S_DRUN;
          end
        end
        S_DRUN: begin
          if (ge) begin
            num <= num - dsh[55:0];
          end
          quo <= {quo[15:0], ge};
          dsh <= {1'b0, dsh[67:1]};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (div_temp) begin
            t_q <= (quo > Q_LIMIT) ? T_HIGH
                                   : ($signed({1'b0, quo}) - $signed({1'b0, KELVIN_CENTI}));
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            r_q <= quo[15:0];
            if (quo == 17'd0) begin
              t_q <= T_LOW;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_LOG;
            end
          end
        end
        S_LOG: begin
          k <= k_c;
          frac <= '0;
          cnt <= LN_STEPS;
          mul_a <= {9'b0, m_init};
          mul_b <= {9'b0, m_init};
          ret <= S_SQ;
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc <= 80'(mul_a[19:0]) * 80'(mul_b);
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc <= acc + ((80'(mul_a[39:20]) * 80'(mul_b)) << 20);
          state <= ret;
        end
        S_SQ: begin
          frac <= frac_n;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            mul_a <= {9'b0, k, frac_n};
            mul_b <= LN2_Q32;
            ret <= S_L;
          end else begin
            mul_a <= {9'b0, m_n};
            mul_b <= {9'b0, m_n};
            ret <= S_SQ;
          end
          state <= S_MUL1;
        end
        S_L: begin
          l_q <= acc[62:32];
          mul_a <= {9'b0, acc[62:32]};
          mul_b <= {9'b0, acc[62:32]};
          ret <= S_L2;
          state <= S_MUL1;
        end
        S_L2: begin
          mul_a <= {6'b0, acc[60:27]};
          mul_b <= {9'b0, l_q};
          ret <= S_L3;
          state <= S_MUL1;
        end
        S_L3: begin
          mul_a <= cfg.coef_c;
          mul_b <= {2'b0, acc[64:27]};
          ret <= S_CL3;
          state <= S_MUL1;
        end
        S_CL3: begin
          d_q <= 52'(cfg.coef_a) + 52'(acc[77:27]);
          mul_a <= cfg.coef_b;
          mul_b <= {9'b0, l_q};
          ret <= S_BL;
          state <= S_MUL1;
        end
        S_BL: begin
          den <= d_n;
          num <= (56'd100 << 48) + 56'(d_n >> 1);
          div_temp <= 1'b1;
          state <= S_DCHK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[test/tb_thermistor_temperature_sma_top.sv]
// Self-checking testbench for thermistor_temperature_sma_top: random and directed
// converter samples, APB register phases, and a field-by-field check of every result.
// Depends on tsma_pkg, tsma_if and the RTL of the block.
module tb_thermistor_temperature_sma_top;
  import tsma_pkg::*;

  typedef struct packed {
    logic [11:0] level;
    logic [15:0] ohms;
    logic signed [17:0] centi;
    logic fault;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  tsma_in_if adc_bus ();
  tsma_out_if res_bus ();

  thermistor_temperature_sma_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .adc_in(adc_bus), .result_out(res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's configuration and window.
  logic [15:0] series_ohms = SERIES_RESET;
  logic [39:0] sh_a = COEF_A_RESET;
  logic [39:0] sh_b = COEF_B_RESET;
  logic [39:0] sh_c = COEF_C_RESET;
  logic [11:0] window_copy [WINDOW_LEN];
  logic [31:0] sum_copy = '0;
  int slot_copy = 0;

  logic [11:0] pending_samples[$];
  reading_t expected_readings[$];
  int failures = 0;
  int samples_sent = 0;
  int readings_seen = 0;
  int faults_seen = 0;
  int hot_seen = 0;
  bit quiet = 1'b0;

  initial begin
    for (int i = 0; i < WINDOW_LEN; i++) window_copy[i] = '0;
  end

  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] ln_q5_27(input logic [15:0] r);
    int k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 0;
    frac = '0;
    while (k < 15 && (r >> (k + 1)) != 0) k++;
    m = 64'(r) << (30 - k);
    for (int i = 0; i < 27; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (((64'(k) << 27) | frac) * 64'(LN2_Q32)) >> 32;
  endfunction

  function automatic logic signed [17:0] centi_from_ohms(input logic [15:0] r);
    logic [63:0] l, l2, l3, d, q;
    if (r == 0) return T_LOW;
    l = ln_q5_27(r);
    l2 = (l * l) >> 27;
    l3 = mul_shift(l2, l, 27);
    d = 64'(sh_a) + mul_shift(64'(sh_b), l, 27) + mul_shift(64'(sh_c), l3, 27);
    if (d == 0) return T_HIGH;
    q = ((64'd100 << 48) + (d >> 1)) / d;
    if (q > 64'(Q_LIMIT)) return T_HIGH;
    return 18'(q - 64'(KELVIN_CENTI));
  endfunction

  function automatic reading_t predict_reading(input logic [11:0] sample);
    reading_t rd;
    logic [31:0] mean;
    logic [63:0] quot;
    sum_copy = sum_copy - window_copy[slot_copy] + sample;
    window_copy[slot_copy] = sample;
    slot_copy = (slot_copy + 1 == WINDOW_LEN) ? 0 : slot_copy + 1;
    mean = sum_copy / WINDOW_LEN;
    if (mean > 4095) mean = 4095;
    rd.fault = 1'b0;
    if (mean == 0) begin
      rd.ohms = 16'd0;
      rd.fault = 1'b1;
    end else if (mean == 4095) begin
      rd.ohms = R_MAX;
      rd.fault = 1'b1;
    end else begin
      quot = (64'(series_ohms) * 64'(mean)) / 64'(4095 - mean);
      if (quot > 64'(R_MAX)) begin
        rd.ohms = R_MAX;
        rd.fault = 1'b1;
      end else begin
        rd.ohms = quot[15:0];
      end
    end
    rd.level = mean[11:0];
    rd.centi = centi_from_ohms(rd.ohms);
    return rd;
  endfunction

  // Sample driver.
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      adc_bus.valid <= 1'b0;
      adc_bus.adc_sample <= '0;
      gap = 0;
    end else begin
      if (adc_bus.valid && adc_bus.ready) begin
        expected_readings.push_back(predict_reading(adc_bus.adc_sample));
        samples_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
      end
      if (adc_bus.valid && !adc_bus.ready) begin
      end else if (gap > 0) begin
        gap--;
        adc_bus.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        adc_bus.valid <= 1'b1;
        adc_bus.adc_sample <= pending_samples.pop_front();
      end else begin
        adc_bus.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls, including one long hold-off.
  int stall = 0;
  bit long_done = 1'b0;
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          $error("unexpected result transfer: level %0d", res_bus.filtered_level);
          failures++;
        end else begin
          want = expected_readings.pop_front();
          if (res_bus.filtered_level !== want.level) begin
            $error("filtered_level expected %0d actual %0d", want.level,
                   res_bus.filtered_level);
            failures++;
          end
          if (res_bus.resistance_ohms !== want.ohms) begin
            $error("resistance_ohms expected %0d actual %0d", want.ohms,
                   res_bus.resistance_ohms);
            failures++;
          end
          if (res_bus.temperature_centi_c !== want.centi) begin
            $error("temperature_centi_c expected %0d actual %0d", want.centi,
                   res_bus.temperature_centi_c);
            failures++;
          end
          if (res_bus.range_fault !== want.fault) begin
            $error("range_fault expected %0d actual %0d", want.fault, res_bus.range_fault);
            failures++;
          end
          if (want.fault) faults_seen++;
          if (want.centi == T_HIGH) hot_seen++;
        end
        if (!long_done && readings_seen == 300) begin
          long_done = 1'b1;
          stall = 2500;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          stall = $urandom_range(1, 12);
        end
      end
      if (stall > 0) begin
        stall--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SERIES: series_ohms = value[15:0];
      REG_COEF_A: sh_a = value[39:0];
      REG_COEF_B: sh_b = value[39:0];
      default: sh_c = value[39:0];
    endcase
  endtask

  task automatic set_config(input logic [15:0] s, input logic [39:0] a,
                            input logic [39:0] b, input logic [39:0] c);
    reg_write(REG_SERIES, 64'(s));
    reg_write(REG_COEF_A, 64'(a));
    reg_write(REG_COEF_B, 64'(b));
    reg_write(REG_COEF_C, 64'(c));
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || adc_bus.valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push_run(input logic [11:0] value, input int n);
    repeat (n) pending_samples.push_back(value);
  endtask

  task automatic queue_random(input int n);
    int left;
    int len;
    int mode;
    logic [11:0] base;
    left = n;
    while (left > 0) begin
      len = $urandom_range(6, 24);
      if (len > left) len = left;
      mode = $urandom_range(0, 5);
      base = 12'($urandom);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0, 1: pending_samples.push_back(12'($urandom));
          2: pending_samples.push_back(12'($urandom_range(0, 6)));
          3: pending_samples.push_back(12'($urandom_range(3590, 4095)));
          4: pending_samples.push_back(base);
          default: pending_samples.push_back(base ^ 12'($urandom_range(0, 15)));
        endcase
      end
      left -= len;
    end
  endtask

  function automatic logic [39:0] random_coef(input logic [39:0] nominal);
    case ($urandom_range(0, 3))
      0: return 40'({$urandom, $urandom});
      1: return 40'(nominal >> $urandom_range(0, 6));
      default: return nominal + 40'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Defaults: empty window, full scale, divider overflow, mid values.
    push_run(12'd0, 2);
    push_run(12'd4095, 12);
    push_run(12'd3700, 12);
    pending_samples.push_back(12'd2048);
    pending_samples.push_back(12'hAAA);
    pending_samples.push_back(12'h555);
    drain();

    // Tiny divider resistor and zero coefficients: zero denominator and
    // a resistance that truncates to zero with a nonzero mean.
    set_config(16'd1, 40'd0, 40'd0, 40'd0);
    push_run(12'd12, 12);
    push_run(12'd3000, 12);
    drain();

    // Largest resistor and coefficients.
    set_config(16'hFFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
    push_run(12'd100, 12);
    push_run(12'd1, 3);
    drain();

    // Very small denominator drives the temperature into saturation.
    set_config(16'd10000, 40'd1, 40'd0, 40'd0);
    push_run(12'd2000, 8);
    drain();

    set_config(SERIES_RESET, COEF_A_RESET, COEF_B_RESET, COEF_C_RESET);
    queue_random(350);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_config(16'($urandom_range(1, 65535)), random_coef(COEF_A_RESET),
                 random_coef(COEF_B_RESET), random_coef(COEF_C_RESET));
      queue_random(80);
      drain();
    end

    set_config(SERIES_RESET, COEF_A_RESET, COEF_B_RESET, COEF_C_RESET);
    queue_random(124);
    drain();
    quiet = 1'b1;
    queue_random(120);
    drain();

    $display("Checked %0d results from %0d samples over 12 register settings;",
             readings_seen, samples_sent);
    $display("%0d carried the range fault and %0d hit the temperature ceiling.",
             faults_seen, hot_seen);
    if (failures == 0 && expected_readings.size() == 0) begin
      $display("thermistor_temperature_sma_top verification clean");
    end else begin
      $display("thermistor_temperature_sma_top verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("thermistor_temperature_sma_top verification failed");
    $finish;
  end

endmodule
